// ===== rtl/table_2d_bilinear_lookup_core_defines.svh =====
// Assertion macros for the table lookup core
`ifndef TABLE_2D_BILINEAR_LOOKUP_CORE_DEFINES_SVH
`define TABLE_2D_BILINEAR_LOOKUP_CORE_DEFINES_SVH

`define TBL_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

`define TBL_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== rtl/tbl2d_pkg.sv =====
package tbl2d_pkg;

  localparam int unsigned MaxRows  = 16;
  localparam int unsigned MaxCols  = 16;
  localparam int unsigned FracBits = 16;
  localparam int unsigned RowIdxW  = $clog2(MaxRows);
  localparam int unsigned ColIdxW  = $clog2(MaxCols);
  localparam int unsigned GridAw   = RowIdxW + ColIdxW;

  localparam logic [2:0] CmdQuery = 3'd0;
  localparam logic [2:0] CmdRowBp = 3'd1;
  localparam logic [2:0] CmdColBp = 3'd2;
  localparam logic [2:0] CmdGrid  = 3'd3;
  localparam logic [2:0] CmdClear = 3'd4;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StRefuse = 2'd1;
  localparam logic [1:0] StAck    = 2'd2;

  localparam logic [1:0] RuleHold   = 2'd0;
  localparam logic [1:0] RuleRefuse = 2'd1;
  localparam logic [1:0] RuleExtrap = 2'd2;

  localparam logic [1:0] AddrMode  = 2'd0;
  localparam logic [1:0] AddrRule  = 2'd1;
  localparam logic [1:0] AddrRows  = 2'd2;
  localparam logic [1:0] AddrCols  = 2'd3;

  typedef struct packed {
    logic        start;
    logic [32:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sh7FFFFFFF) r = 32'h7FFFFFFF;
    else if (v < -66'sh80000000) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/tbl2d_div.sv =====
module tbl2d_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbl2d_pkg::div_req_t req_i,
  output tbl2d_pkg::div_rsp_t rsp_o
);
  // signed dividend (arg-bp)<<FracBits, 49 bits; positive divisor; restoring
  localparam int unsigned NumW = 32 + 1 + tbl2d_pkg::FracBits;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] num_q, num_d;
  logic [32:0]     rem_q, rem_d;
  logic [32:0]     den_q, den_d;
  logic            neg_q, neg_d;
  logic            done_q, done_d;
  logic [33:0]     trial;
  logic signed [NumW:0] qs;
  logic signed [NumW-1:0] sn;
  logic [NumW-1:0] mag;

  always_comb begin
    sn  = NumW'($signed(req_i.num)) <<< tbl2d_pkg::FracBits;
    mag = sn[NumW-1] ? NumW'(-sn) : sn;
    trial = {rem_q, num_q[NumW-1]} - {1'b0, den_q};
    busy_d = busy_q;
    cnt_d = cnt_q;
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    neg_d = neg_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d = CntW'(NumW);
      num_d = mag;
      rem_d = '0;
      den_d = {1'b0, req_i.den};
      neg_d = sn[NumW-1];
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d = trial[32:0];
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], num_q[NumW-1]};
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    qs = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
    rsp_o.done = done_q;
    rsp_o.quo = tbl2d_pkg::sat32(66'(qs));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end
endmodule

// ===== rtl/tbl2d_blend.sv =====
module tbl2d_blend (
  input  logic        clk_i,
  input  logic [31:0] v0_i,
  input  logic [31:0] v1_i,
  input  logic [31:0] frac_i,
  output logic [31:0] res_o
);
  // difference times fraction is registered; the floor shift, add and saturate follow combinationally
  logic signed [32:0] diff;
  logic signed [65:0] prod_q;
  logic signed [31:0] v0_q;
  logic signed [65:0] sum;

  always_comb begin
    diff = 33'($signed(v1_i)) - 33'($signed(v0_i));
    sum  = 66'(v0_q) + (prod_q >>> tbl2d_pkg::FracBits);
    res_o = tbl2d_pkg::sat32(sum);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 66'(diff) * 66'($signed(frac_i));
    v0_q   <= $signed(v0_i);
  end
endmodule

// ===== rtl/table_2d_bilinear_lookup_core.sv =====
// Two-axis breakpoint table lookup, Q16.16. One item at a time. A bilinear
// query runs, per axis, an edge fetch, a range check that may refuse it,
// up to five search probes plus one, a pair fetch, one shared 49-step
// restoring divider (skipped on a non-positive span) and a step to advance,
// then four grid reads and three blends on one shared multiply-add unit.
// Nearest-low reads one grid entry and skips the blends. A finished result
// sits in an output register, so the next item starts while it waits; the
// block stalls only when a second result is ready before the first is taken.
// The breakpoint and grid stores hold garbage until written.
`include "table_2d_bilinear_lookup_core_defines.svh"
module table_2d_bilinear_lookup_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic signed [31:0] row_arg_i,
  input  logic signed [31:0] col_arg_i,
  input  logic [3:0]  row_index_i,
  input  logic [3:0]  col_index_i,
  input  logic signed [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic [1:0]  status_o,
  output logic [31:0] out_count_o,
  output logic [31:0] worst_dist_o
);
  localparam int unsigned RW = tbl2d_pkg::RowIdxW;
  localparam int unsigned GA = tbl2d_pkg::GridAw;
  localparam int unsigned CW = 5;
  localparam logic [31:0] One = 32'(1) << tbl2d_pkg::FracBits;

  typedef enum logic [14:0] {
    SIdle  = 15'b000000000000001,
    SExec  = 15'b000000000000010,
    SEdge  = 15'b000000000000100,
    SChk   = 15'b000000000001000,
    SSrch  = 15'b000000000010000,
    SPair  = 15'b000000000100000,
    SPairW = 15'b000000001000000,
    SDiv   = 15'b000000010000000,
    SDivW  = 15'b000000100000000,
    SGrd   = 15'b000001000000000,
    SGrdW  = 15'b000010000000000,
    SBl    = 15'b000100000000000,
    SBlW   = 15'b001000000000000,
    SOut   = 15'b010000000000000,
    SNext  = 15'b100000000000000
  } state_e;

  state_e st_q;

  logic [31:0] row_mem [tbl2d_pkg::MaxRows];
  logic [31:0] col_mem [tbl2d_pkg::MaxCols];
  logic [31:0] grid_mem [tbl2d_pkg::MaxRows * tbl2d_pkg::MaxCols];

  logic        mode_q;
  logic [1:0]  rule_q;
  logic [4:0]  rcnt_q, ccnt_q;
  logic [31:0] tally_q, worst_q;

  logic [2:0]  cmd_q;
  logic [31:0] rarg_q, carg_q, wd_q;
  logic [3:0]  ri_q, ci_q;
  logic        ax_q;
  logic [1:0]  ph_q;
  logic [31:0] bp_rd_q, lo_q, eff_q, span_q;
  logic [32:0] d_q;
  logic [4:0]  first_q, count_q, n_q;
  logic [RW-1:0] rd_a_q, li_q, lj_q;
  logic [31:0] fr_q, fc_q;
  logic [31:0] g_q [4];
  logic [1:0]  gi_q;
  logic [GA-1:0] g_addr_q;
  logic [31:0] g_rd_q;
  logic [31:0] b0_q, b1_q;
  logic [31:0] res_q;
  logic [1:0]  stat_q;
  logic        ov_q;
  logic [31:0] o_res_q, o_cnt_q, o_worst_q;
  logic [1:0]  o_stat_q;
  logic        out_load;
  logic [1:0]  bi_q;
  logic [31:0] bv0, bv1, bfr, bres;

  tbl2d_pkg::div_req_t dreq;
  tbl2d_pkg::div_rsp_t drsp;

  tbl2d_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  always_comb begin
    bv0 = (bi_q == 2'd2) ? b0_q : g_q[{bi_q[0], 1'b0}];
    bv1 = (bi_q == 2'd2) ? b1_q : g_q[{bi_q[0], 1'b1}];
    bfr = (bi_q == 2'd2) ? fr_q : fc_q;
  end

  tbl2d_blend u_blend (.clk_i, .v0_i(bv0), .v1_i(bv1), .frac_i(bfr), .res_o(bres));

  // APB
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      tbl2d_pkg::AddrMode: prdata = {31'b0, mode_q};
      tbl2d_pkg::AddrRule: prdata = {30'b0, rule_q};
      tbl2d_pkg::AddrRows: prdata = {27'b0, rcnt_q};
      tbl2d_pkg::AddrCols: prdata = {27'b0, ccnt_q};
      default: prdata = '0;
    endcase
  end

  function automatic logic [4:0] used(input logic [4:0] c, input logic [4:0] m);
    logic [4:0] r;
    r = (c < 5'd2) ? 5'd2 : ((c > m) ? m : c);
    return r;
  endfunction

  localparam logic [4:0] MaxR = CW'(tbl2d_pkg::MaxRows);
  localparam logic [4:0] MaxC = CW'(tbl2d_pkg::MaxCols);

  assign in_ready_o = (st_q == SIdle);
  assign out_valid_o = ov_q;
  assign result_value_o = o_res_q;
  assign status_o = o_stat_q;
  assign out_count_o = o_cnt_q;
  assign worst_dist_o = o_worst_q;
  assign out_load = (st_q == SOut) && (!ov_q || out_ready_i);

  logic signed [32:0] arg_s, lo_s, hi_s, exc;
  logic [4:0] mid;
  logic [4:0] upc;

  always_comb begin
    arg_s = 33'($signed(ax_q ? carg_q : rarg_q));
    lo_s  = 33'($signed(lo_q));
    hi_s  = 33'($signed(bp_rd_q));
    exc   = (arg_s < lo_s) ? lo_s - arg_s : arg_s - hi_s;
    mid   = first_q + (count_q >> 1);
    upc   = (first_q < 5'd1) ? 5'd1 : ((first_q > n_q - 5'd1) ? n_q - 5'd1 : first_q);
    dreq.start = (st_q == SDiv);
    dreq.num   = d_q;
    dreq.den   = span_q;
  end

  logic [RW-1:0] mid_a;
  assign mid_a = mid[RW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      mode_q <= 1'b0;
      rule_q <= tbl2d_pkg::RuleHold;
      rcnt_q <= 5'd2;
      ccnt_q <= 5'd2;
      tally_q <= '0;
      worst_q <= '0;
      ov_q <= 1'b0;
      ph_q <= '0;
      ax_q <= 1'b0;
      gi_q <= '0;
      bi_q <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[3:2])
          tbl2d_pkg::AddrMode: mode_q <= pwdata[0];
          tbl2d_pkg::AddrRule: rule_q <= pwdata[1:0];
          tbl2d_pkg::AddrRows: rcnt_q <= pwdata[4:0];
          tbl2d_pkg::AddrCols: ccnt_q <= pwdata[4:0];
          default: ;
        endcase
      end
      if (out_load) ov_q <= 1'b1;
      else if (ov_q && out_ready_i) ov_q <= 1'b0;
      unique case (st_q)
        SIdle: if (in_valid_i) st_q <= SExec;
        SExec: begin
          res_q <= '0;
          stat_q <= tbl2d_pkg::StAck;
          ax_q <= 1'b0;
          ph_q <= '0;
          if (cmd_q == tbl2d_pkg::CmdClear) begin
            tally_q <= '0;
            worst_q <= '0;
          end
          if (cmd_q == tbl2d_pkg::CmdQuery) begin
            n_q <= used(rcnt_q, MaxR);
            rd_a_q <= '0;
            st_q <= SEdge;
          end else st_q <= SOut;
        end
        SEdge: begin
          // ph 0: issue low, 1: capture low / issue high, 2: high ready
          if (ph_q == 2'd0) begin
            rd_a_q <= RW'(n_q - 5'd1);
            ph_q <= 2'd1;
          end else if (ph_q == 2'd1) begin
            lo_q <= bp_rd_q;
            ph_q <= 2'd2;
          end else begin
            ph_q <= 2'd0;
            st_q <= SChk;
          end
        end
        SChk: begin
          if ((arg_s < lo_s || arg_s > hi_s) && rule_q != tbl2d_pkg::RuleExtrap) begin
            eff_q <= (arg_s < lo_s) ? lo_q : bp_rd_q;
          end else begin
            eff_q <= arg_s[31:0];
          end
          if (arg_s < lo_s || arg_s > hi_s) begin
            if (tally_q != 32'hFFFFFFFF) tally_q <= tally_q + 1'b1;
            if (exc[31:0] > worst_q) worst_q <= exc[31:0];
          end
          if ((arg_s < lo_s || arg_s > hi_s) && rule_q == tbl2d_pkg::RuleRefuse) begin
            stat_q <= tbl2d_pkg::StRefuse;
            st_q <= SOut;
          end else begin
            first_q <= '0;
            count_q <= n_q;
            ph_q <= 2'd0;
            st_q <= SSrch;
          end
        end
        SSrch: begin
          // ph 0: issue probe, 1: wait, 2: compare
          if (count_q == 5'd0) begin
            rd_a_q <= RW'(upc - 5'd1);
            ph_q <= 2'd0;
            st_q <= SPair;
          end else if (ph_q == 2'd0) begin
            rd_a_q <= mid_a;
            ph_q <= 2'd1;
          end else if (ph_q == 2'd1) begin
            ph_q <= 2'd2;
          end else begin
            if (!($signed(eff_q) < $signed(bp_rd_q))) begin
              first_q <= mid + 5'd1;
              count_q <= count_q - (count_q >> 1) - 5'd1;
            end else count_q <= count_q >> 1;
            ph_q <= 2'd0;
          end
        end
        SPair: begin
          rd_a_q <= RW'(upc);
          if (ax_q) lj_q <= RW'(upc - 5'd1); else li_q <= RW'(upc - 5'd1);
          st_q <= SPairW;
        end
        SPairW: begin
          if (ph_q == 2'd0) begin
            lo_q <= bp_rd_q;
            ph_q <= 2'd1;
          end else begin
            span_q <= 32'($signed(bp_rd_q) - $signed(lo_q));
            d_q <= 33'($signed(eff_q)) - 33'($signed(lo_q));
            if ($signed(bp_rd_q) <= $signed(lo_q)) begin
              if (ax_q) fc_q <= '0; else fr_q <= '0;
              st_q <= SNext;
            end else st_q <= SDiv;
          end
        end
        SDiv: st_q <= SDivW;
        SDivW: if (drsp.done) begin
          if (ax_q) fc_q <= drsp.quo; else fr_q <= drsp.quo;
          st_q <= SNext;
        end
        SNext: begin
          if (!ax_q) begin
            ax_q <= 1'b1;
            n_q <= used(ccnt_q, MaxC);
            rd_a_q <= '0;
            ph_q <= '0;
            st_q <= SEdge;
          end else begin
            stat_q <= tbl2d_pkg::StOk;
            gi_q <= '0;
            ph_q <= '0;
            st_q <= SGrd;
          end
        end
        SGrd: begin
          if (mode_q) begin
            g_addr_q <= {($signed(fr_q) >= $signed(One)) ? li_q + 1'b1 : li_q,
                         ($signed(fc_q) >= $signed(One)) ? lj_q + 1'b1 : lj_q};
          end else begin
            g_addr_q <= {li_q + RW'(gi_q[1]), lj_q + RW'(gi_q[0])};
          end
          st_q <= SGrdW;
          ph_q <= '0;
        end
        SGrdW: begin
          if (ph_q == 2'd0) ph_q <= 2'd1;
          else begin
            g_q[gi_q] <= g_rd_q;
            if (mode_q) begin
              res_q <= g_rd_q;
              st_q <= SOut;
            end else if (gi_q == 2'd3) begin
              bi_q <= '0;
              ph_q <= '0;
              st_q <= SBl;
            end else begin
              gi_q <= gi_q + 1'b1;
              st_q <= SGrd;
            end
          end
        end
        SBl: begin
          ph_q <= '0;
          st_q <= SBlW;
        end
        SBlW: begin
          if (ph_q == 2'd0) ph_q <= 2'd1;
          else begin
            if (bi_q == 2'd0) b0_q <= bres;
            else if (bi_q == 2'd1) b1_q <= bres;
            else res_q <= bres;
            if (bi_q == 2'd2) st_q <= SOut;
            else begin
              bi_q <= bi_q + 1'b1;
              st_q <= SBl;
            end
          end
        end
        SOut: begin
          if (out_load) st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_res_q <= res_q;
      o_stat_q <= stat_q;
      o_cnt_q <= tally_q;
      o_worst_q <= worst_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_i;
      rarg_q <= row_arg_i;
      carg_q <= col_arg_i;
      ri_q <= row_index_i;
      ci_q <= col_index_i;
      wd_q <= write_data_i;
    end
    if (st_q == SExec) begin
      if (cmd_q == tbl2d_pkg::CmdRowBp) row_mem[ri_q] <= wd_q;
      if (cmd_q == tbl2d_pkg::CmdColBp) col_mem[ci_q] <= wd_q;
      if (cmd_q == tbl2d_pkg::CmdGrid) grid_mem[{ri_q, ci_q}] <= wd_q;
    end
    bp_rd_q <= ax_q ? col_mem[rd_a_q] : row_mem[rd_a_q];
    g_rd_q <= grid_mem[g_addr_q];
  end

  `TBL_ASSERT_IMPL(a_busy_not_ready, clk_i, rst_ni, st_q != SIdle, !in_ready_o)
  `TBL_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_valid_i && in_ready_o, st_q == SExec)
  `TBL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, ov_q && !out_ready_i, ov_q)
endmodule
